// File: rtl/rlkp_pkg.sv
// Shared types and constants for the RGB LED mixer with knob pickup.
package rlkp_pkg;

   localparam int KNOB_BITS = 10;
   localparam int NUM_CH    = 3;

   localparam logic [KNOB_BITS-1:0] KNOB_FULL      = 10'd1023;
   localparam logic [KNOB_BITS-1:0] DEADBAND_RESET = 10'd5;

   localparam logic [1:0] MODE_UNINIT    = 2'd0;
   localparam logic [1:0] MODE_SINGLE    = 2'd1;
   localparam logic [1:0] MODE_COMPOSITE = 2'd2;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic                 mode_button_level;
      logic                 color_button_level;
      logic [KNOB_BITS-1:0] knob_sample;
   } item_type;

   typedef struct packed {
      logic [1:0] display_mode;
      logic [1:0] active_channel;
      logic       mode_indicator;
      logic       color_indicator;
   } status_type;

   // channel rotation; the unused code lands on green
   function automatic logic [1:0] next_channel(input logic [1:0] ch);
      logic [1:0] nxt;
      case (ch)
         CH_RED:   nxt = CH_GREEN;
         CH_GREEN: nxt = CH_BLUE;
         CH_BLUE:  nxt = CH_RED;
         default:  nxt = CH_GREEN;
      endcase
      return nxt;
   endfunction

endpackage

// File: rtl/rgb_led_mixer_knob_pickup.sv
// Top level of the RGB LED mixer with knob soft pickup.
// One poll per clock cycle sustained while rsp_ready stays high. A poll waits
// in the input register, and the state update then loads its result into
// the result register. That update covers button release decode, channel
// rotation, knob pickup and, for composite mode, three multiply-and-fold
// divisions by 1023. The result then waits there until rsp_ready takes it.
// A new poll is taken while a result waits, as long as the input register
// is free. The knob deadband register resets to 5; it is to be written
// through csr_write_enable/csr_write_data only while no poll is in flight,
// which the block itself does not enforce.
module rgb_led_mixer_knob_pickup #(
   parameter int DUTY_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode_button_level,
   input  logic        req_color_button_level,
   input  logic [9:0]  req_knob_sample,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_red_duty,
   output logic [9:0]  rsp_green_duty,
   output logic [9:0]  rsp_blue_duty,
   output logic [1:0]  rsp_display_mode,
   output logic [1:0]  rsp_active_channel,
   output logic        rsp_mode_indicator,
   output logic        rsp_color_indicator,

   input  logic        csr_write_enable,
   input  logic [9:0]  csr_write_data
);

   logic                                   in_valid_ff, in_valid_in;
   rlkp_pkg::item_type                     item_ff;
   logic                                   out_valid_ff, out_valid_in;
   logic [rlkp_pkg::NUM_CH-1:0][DUTY_BITS-1:0] duty_next;
   logic [rlkp_pkg::NUM_CH-1:0][9:0]       duty_out_ff;
   rlkp_pkg::status_type                   status_next, status_ff;
   logic [rlkp_pkg::KNOB_BITS-1:0]         deadband_ff;
   logic                                   step;
   logic                                   req_xfer;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         deadband_ff  <= rlkp_pkg::DEADBAND_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) deadband_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= '{mode_button_level:  req_mode_button_level,
                      color_button_level: req_color_button_level,
                      knob_sample:        req_knob_sample};
      end
      if (step) begin
         for (int i = 0; i < rlkp_pkg::NUM_CH; i++) begin
            duty_out_ff[i] <= 10'(duty_next[i]);
         end
         status_ff <= status_next;
      end
   end

   rlkp_core #(.DUTY_BITS(DUTY_BITS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (item_ff),
      .deadband    (deadband_ff),
      .duty_next   (duty_next),
      .status_next (status_next)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_red_duty        = duty_out_ff[0];
   assign rsp_green_duty      = duty_out_ff[1];
   assign rsp_blue_duty       = duty_out_ff[2];
   assign rsp_display_mode    = status_ff.display_mode;
   assign rsp_active_channel  = status_ff.active_channel;
   assign rsp_mode_indicator  = status_ff.mode_indicator;
   assign rsp_color_indicator = status_ff.color_indicator;

`ifndef ASSERT_OFF
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("poll processed but no result registered");

   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(item_ff))
      else $error("stalled poll lost from input register");

   a_transfer_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted poll not held in input register");
`endif

endmodule

// File: rtl/rlkp_scale.sv
// One channel of composite scaling: floor(brightness * knob / 1023).
module rlkp_scale #(
   parameter int DUTY_BITS = 10
) (
   input  logic [DUTY_BITS-1:0]          bright,
   input  logic [rlkp_pkg::KNOB_BITS-1:0] knob,
   output logic [DUTY_BITS-1:0]          scaled
);

   localparam int PW = DUTY_BITS + rlkp_pkg::KNOB_BITS;
   localparam int SW = ((DUTY_BITS > rlkp_pkg::KNOB_BITS) ? DUTY_BITS
                                                         : rlkp_pkg::KNOB_BITS) + 1;
   localparam int HW = SW - 10;
   localparam int QW = DUTY_BITS + 1;

   logic [PW-1:0]        product;
   logic [DUTY_BITS-1:0] hi;
   logic [SW-1:0]        fold1;
   logic [HW-1:0]        hi2;
   logic [10:0]          fold2;
   logic                 carry;
   logic [QW-1:0]        quot;

   // x = 1024*hi + lo = 1023*hi + (hi + lo); fold twice, then one correction
   assign product = PW'(bright) * PW'(knob);
   assign hi      = product[PW-1:10];
   assign fold1   = SW'(hi) + SW'(product[9:0]);
   assign hi2     = fold1[SW-1:10];
   assign fold2   = 11'(hi2) + 11'(fold1[9:0]);
   assign carry   = (fold2 >= 11'(rlkp_pkg::KNOB_FULL));
   assign quot    = QW'(hi) + QW'(hi2) + QW'(carry);
   assign scaled  = quot[DUTY_BITS-1:0];

endmodule

// File: rtl/rlkp_core.sv
// Mixer state and the combinational poll update: buttons, channel, knob pickup.
module rlkp_core #(
   parameter int DUTY_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  rlkp_pkg::item_type                     item,
   input  logic [rlkp_pkg::KNOB_BITS-1:0]         deadband,
   output logic [rlkp_pkg::NUM_CH-1:0][DUTY_BITS-1:0] duty_next,
   output rlkp_pkg::status_type                   status_next
);

   localparam int CW = (DUTY_BITS > rlkp_pkg::KNOB_BITS) ? DUTY_BITS
                                                         : rlkp_pkg::KNOB_BITS;

   logic [rlkp_pkg::NUM_CH-1:0][DUTY_BITS-1:0] duty_ff, duty_in;
   logic [rlkp_pkg::NUM_CH-1:0][DUTY_BITS-1:0] bright_ff, bright_in;
   logic [rlkp_pkg::NUM_CH-1:0][DUTY_BITS-1:0] scaled;
   logic [1:0]                     chan_ff, chan_in;
   logic [1:0]                     mode_ff, mode_in;
   logic                           spick_ff, spick_in;
   logic                           cpick_ff, cpick_in;
   logic [rlkp_pkg::KNOB_BITS-1:0] last_ff, last_in;
   logic [rlkp_pkg::KNOB_BITS-1:0] clast_ff, clast_in;
   logic                           mheld_ff, mheld_in;
   logic                           cheld_ff, cheld_in;
   logic [rlkp_pkg::KNOB_BITS-1:0] knob_diff;
   logic                           knob_moved;

   // brightness only changes in single-colour mode, so composite uses the held values
   for (genvar g = 0; g < rlkp_pkg::NUM_CH; g++) begin : g_scale
      rlkp_scale #(.DUTY_BITS(DUTY_BITS)) u_scale (
         .bright (bright_ff[g]),
         .knob   (item.knob_sample),
         .scaled (scaled[g])
      );
   end

   always_comb begin
      duty_in   = duty_ff;
      bright_in = bright_ff;
      chan_in   = chan_ff;
      mode_in   = mode_ff;
      spick_in  = spick_ff;
      cpick_in  = cpick_ff;
      last_in   = last_ff;
      clast_in  = clast_ff;
      mheld_in  = mheld_ff;
      cheld_in  = cheld_ff;

      knob_diff  = (item.knob_sample > last_ff) ? (item.knob_sample - last_ff)
                                                : (last_ff - item.knob_sample);
      knob_moved = (knob_diff > deadband);

      // mode button, acts on release
      if (!item.mode_button_level) begin
         mheld_in = 1'b1;
      end else if (mheld_ff) begin
         mheld_in = 1'b0;
         duty_in  = '0;
         spick_in = 1'b0;
         cpick_in = 1'b0;
         case (mode_ff)
            rlkp_pkg::MODE_UNINIT: begin
               mode_in = rlkp_pkg::MODE_SINGLE;
            end
            rlkp_pkg::MODE_COMPOSITE: begin
               for (int i = 0; i < rlkp_pkg::NUM_CH; i++) begin
                  if (chan_ff == 2'(i)) duty_in[i] = bright_ff[i];
               end
               mode_in = rlkp_pkg::MODE_SINGLE;
            end
            default: begin
               duty_in = bright_ff;
               mode_in = rlkp_pkg::MODE_COMPOSITE;
            end
         endcase
      end

      // colour button, acts on release in single-colour mode only
      if (!item.color_button_level) begin
         cheld_in = 1'b1;
      end else if (cheld_ff) begin
         cheld_in = 1'b0;
         if (mode_in == rlkp_pkg::MODE_SINGLE) begin
            for (int i = 0; i < rlkp_pkg::NUM_CH; i++) begin
               if (chan_ff == 2'(i)) begin
                  bright_in[i] = duty_in[i];
                  duty_in[i]   = '0;
               end
            end
            chan_in = rlkp_pkg::next_channel(chan_ff);
            for (int i = 0; i < rlkp_pkg::NUM_CH; i++) begin
               if (chan_in == 2'(i)) duty_in[i] = bright_in[i];
            end
            spick_in = 1'b0;
         end
      end

      // knob with soft pickup
      if (knob_moved) begin
         if (mode_in == rlkp_pkg::MODE_SINGLE) begin
            for (int i = 0; i < rlkp_pkg::NUM_CH; i++) begin
               if (chan_in == 2'(i)) begin
                  if (CW'(item.knob_sample) == CW'(bright_in[i])) spick_in = 1'b1;
                  if (spick_in) duty_in[i] = DUTY_BITS'(item.knob_sample);
               end
            end
            last_in = item.knob_sample;
         end else if (mode_in == rlkp_pkg::MODE_COMPOSITE) begin
            if (item.knob_sample == clast_ff) begin
               cpick_in = 1'b1;
            end else if (cpick_in) begin
               duty_in  = scaled;
               clast_in = item.knob_sample;
            end
            last_in = item.knob_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff   <= '0;
         bright_ff <= {rlkp_pkg::NUM_CH{DUTY_BITS'(rlkp_pkg::KNOB_FULL)}};
         chan_ff   <= rlkp_pkg::CH_RED;
         mode_ff   <= rlkp_pkg::MODE_UNINIT;
         spick_ff  <= 1'b0;
         cpick_ff  <= 1'b0;
         last_ff   <= '0;
         clast_ff  <= '0;
         mheld_ff  <= 1'b0;
         cheld_ff  <= 1'b0;
      end else if (step) begin
         duty_ff   <= duty_in;
         bright_ff <= bright_in;
         chan_ff   <= chan_in;
         mode_ff   <= mode_in;
         spick_ff  <= spick_in;
         cpick_ff  <= cpick_in;
         last_ff   <= last_in;
         clast_ff  <= clast_in;
         mheld_ff  <= mheld_in;
         cheld_ff  <= cheld_in;
      end
   end

   assign duty_next   = duty_in;
   assign status_next = '{display_mode:    mode_in,
                          active_channel:  chan_in,
                          mode_indicator:  mheld_in,
                          color_indicator: cheld_in};

`ifndef ASSERT_OFF
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(duty_ff) && $stable(mode_ff) && $stable(chan_ff))
      else $error("mixer state changed without a poll");

   a_no_return_uninit: assert property (@(posedge clock) disable iff (reset)
      step && mode_ff != rlkp_pkg::MODE_UNINIT |=> mode_ff != rlkp_pkg::MODE_UNINIT)
      else $error("mode went back to uninitialised");

   a_chan_single_only: assert property (@(posedge clock) disable iff (reset)
      step && mode_in != rlkp_pkg::MODE_SINGLE |=> chan_ff == $past(chan_ff))
      else $error("channel moved outside single-colour mode");
`endif

endmodule

// File: sim/rlkp_result_checker.sv
// Result checker for the RGB LED mixer: follows each poll, predicts its result and compares.
`timescale 1ns / 1ps
module rlkp_result_checker (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_mode_button_level,
   input  logic                           req_color_button_level,
   input  logic [rlkp_pkg::KNOB_BITS-1:0] req_knob_sample,

   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [rlkp_pkg::KNOB_BITS-1:0] rsp_red_duty,
   input  logic [rlkp_pkg::KNOB_BITS-1:0] rsp_green_duty,
   input  logic [rlkp_pkg::KNOB_BITS-1:0] rsp_blue_duty,
   input  logic [1:0]                     rsp_display_mode,
   input  logic [1:0]                     rsp_active_channel,
   input  logic                           rsp_mode_indicator,
   input  logic                           rsp_color_indicator,

   input  logic                           csr_write_enable,
   input  logic [rlkp_pkg::KNOB_BITS-1:0] csr_write_data,

   output int                             fail_count,
   output int                             results_pending
);

   typedef struct packed {
      logic [rlkp_pkg::KNOB_BITS-1:0] red;
      logic [rlkp_pkg::KNOB_BITS-1:0] green;
      logic [rlkp_pkg::KNOB_BITS-1:0] blue;
      rlkp_pkg::status_type           status;
   } mix_result_type;

   // mirror of the mixer state
   logic [rlkp_pkg::KNOB_BITS-1:0] duty [rlkp_pkg::NUM_CH];
   logic [rlkp_pkg::KNOB_BITS-1:0] brightness [rlkp_pkg::NUM_CH];
   logic [1:0]                     sel_ch;
   logic [1:0]                     mode;
   logic                           single_locked;
   logic                           composite_locked;
   logic [rlkp_pkg::KNOB_BITS-1:0] counted_knob;
   logic [rlkp_pkg::KNOB_BITS-1:0] composite_knob;
   logic [rlkp_pkg::KNOB_BITS-1:0] deadband;
   logic                           mode_down;
   logic                           color_down;

   mix_result_type expected_mix [$];
   int             mismatches = 0;
   int             pending_count = 0;

   assign fail_count      = mismatches;
   assign results_pending = pending_count;

   task automatic report_failure(input string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_failure($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
   endtask

   function automatic void clear_mixer();
      for (int i = 0; i < rlkp_pkg::NUM_CH; i++) begin
         duty[i]       = '0;
         brightness[i] = rlkp_pkg::KNOB_FULL;
      end
      sel_ch           = rlkp_pkg::CH_RED;
      mode             = rlkp_pkg::MODE_UNINIT;
      single_locked    = 1'b0;
      composite_locked = 1'b0;
      counted_knob     = '0;
      composite_knob   = '0;
      deadband         = rlkp_pkg::DEADBAND_RESET;
      mode_down        = 1'b0;
      color_down       = 1'b0;
   endfunction

   function automatic void step_mode();
      for (int i = 0; i < rlkp_pkg::NUM_CH; i++)
         duty[i] = '0;
      single_locked    = 1'b0;
      composite_locked = 1'b0;
      case (mode)
         rlkp_pkg::MODE_UNINIT: begin
            mode = rlkp_pkg::MODE_SINGLE;
         end
         rlkp_pkg::MODE_COMPOSITE: begin
            if (sel_ch < rlkp_pkg::NUM_CH)
               duty[sel_ch] = brightness[sel_ch];
            mode = rlkp_pkg::MODE_SINGLE;
         end
         default: begin
            for (int i = 0; i < rlkp_pkg::NUM_CH; i++)
               duty[i] = brightness[i];
            mode = rlkp_pkg::MODE_COMPOSITE;
         end
      endcase
   endfunction

   function automatic void step_channel();
      if (sel_ch < rlkp_pkg::NUM_CH) begin
         brightness[sel_ch] = duty[sel_ch];
         duty[sel_ch]       = '0;
      end
      sel_ch           = 2'((int'(sel_ch) + 1) % rlkp_pkg::NUM_CH);
      duty[sel_ch]     = brightness[sel_ch];
      single_locked    = 1'b0;
   endfunction

   function automatic void take_knob(input logic [rlkp_pkg::KNOB_BITS-1:0] k);
      logic [rlkp_pkg::KNOB_BITS-1:0] diff;
      diff = (k > counted_knob) ? k - counted_knob : counted_knob - k;
      if (diff <= deadband)
         return;
      if (mode == rlkp_pkg::MODE_SINGLE) begin
         if (sel_ch < rlkp_pkg::NUM_CH) begin
            // soft pickup: the knob must first land on the stored level
            if (k == brightness[sel_ch])
               single_locked = 1'b1;
            if (single_locked)
               duty[sel_ch] = k;
         end
         counted_knob = k;
      end else if (mode == rlkp_pkg::MODE_COMPOSITE) begin
         if (k == composite_knob) begin
            composite_locked = 1'b1;
         end else if (composite_locked) begin
            for (int i = 0; i < rlkp_pkg::NUM_CH; i++)
               duty[i] = rlkp_pkg::KNOB_BITS'((32'(brightness[i]) * 32'(k))
                                              / 32'(rlkp_pkg::KNOB_FULL));
            composite_knob = k;
         end
         counted_knob = k;
      end
   endfunction

   function automatic mix_result_type apply_poll(input logic mode_lvl, input logic color_lvl,
                                                 input logic [rlkp_pkg::KNOB_BITS-1:0] k);
      mix_result_type r;
      if (!mode_lvl) begin
         mode_down = 1'b1;
      end else if (mode_down) begin
         mode_down = 1'b0;
         step_mode();
      end
      if (!color_lvl) begin
         color_down = 1'b1;
      end else if (color_down) begin
         color_down = 1'b0;
         if (mode == rlkp_pkg::MODE_SINGLE)
            step_channel();
      end
      take_knob(k);
      r.red                    = duty[rlkp_pkg::CH_RED];
      r.green                  = duty[rlkp_pkg::CH_GREEN];
      r.blue                   = duty[rlkp_pkg::CH_BLUE];
      r.status.display_mode    = mode;
      r.status.active_channel  = sel_ch;
      r.status.mode_indicator  = mode_down;
      r.status.color_indicator = color_down;
      return r;
   endfunction

   always @(posedge clock) begin : track
      mix_result_type want;
      if (reset) begin
         clear_mixer();
         expected_mix.delete();
      end else begin
         if (csr_write_enable)
            deadband = csr_write_data;
         if (req_valid && req_ready)
            expected_mix.push_back(apply_poll(req_mode_button_level, req_color_button_level,
                                              req_knob_sample));
         if (rsp_valid && rsp_ready) begin
            if (expected_mix.size() == 0) begin
               report_failure("result transfer with no poll outstanding");
            end else begin
               want = expected_mix.pop_front();
               check_field("red_duty", int'(rsp_red_duty), int'(want.red));
               check_field("green_duty", int'(rsp_green_duty), int'(want.green));
               check_field("blue_duty", int'(rsp_blue_duty), int'(want.blue));
               check_field("display_mode", int'(rsp_display_mode),
                           int'(want.status.display_mode));
               check_field("active_channel", int'(rsp_active_channel),
                           int'(want.status.active_channel));
               check_field("mode_indicator", int'(rsp_mode_indicator),
                           int'(want.status.mode_indicator));
               check_field("color_indicator", int'(rsp_color_indicator),
                           int'(want.status.color_indicator));
            end
         end
      end
      pending_count <= expected_mix.size();
   end

endmodule

// File: sim/tb_rgb_led_mixer_knob_pickup.sv
// Testbench top for the RGB LED mixer: drives polls, deadband writes and result stalls.
`timescale 1ns / 1ps
module tb_rgb_led_mixer_knob_pickup;

   localparam int STALL_LIMIT   = 2000;
   localparam int HISTORY_DEPTH = 16;
   localparam int NUM_PHASES    = 7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_mode_button_level = 1'b1;
   logic                           req_color_button_level = 1'b1;
   logic [rlkp_pkg::KNOB_BITS-1:0] req_knob_sample = '0;

   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [rlkp_pkg::KNOB_BITS-1:0] rsp_red_duty;
   logic [rlkp_pkg::KNOB_BITS-1:0] rsp_green_duty;
   logic [rlkp_pkg::KNOB_BITS-1:0] rsp_blue_duty;
   logic [1:0]                     rsp_display_mode;
   logic [1:0]                     rsp_active_channel;
   logic                           rsp_mode_indicator;
   logic                           rsp_color_indicator;

   logic                           csr_write_enable = 1'b0;
   logic [rlkp_pkg::KNOB_BITS-1:0] csr_write_data = '0;

   int                             fail_count;
   int                             results_pending;

   bit                             steady_flow = 1'b0;
   logic [rlkp_pkg::KNOB_BITS-1:0] deadband_now = rlkp_pkg::DEADBAND_RESET;
   logic [rlkp_pkg::KNOB_BITS-1:0] last_knob_sent = '0;
   logic [rlkp_pkg::KNOB_BITS-1:0] knob_history [HISTORY_DEPTH];
   int                             history_slot = 0;

   always #1 clock = ~clock;

   rgb_led_mixer_knob_pickup DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode_button_level  (req_mode_button_level),
      .req_color_button_level (req_color_button_level),
      .req_knob_sample        (req_knob_sample),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_red_duty           (rsp_red_duty),
      .rsp_green_duty         (rsp_green_duty),
      .rsp_blue_duty          (rsp_blue_duty),
      .rsp_display_mode       (rsp_display_mode),
      .rsp_active_channel     (rsp_active_channel),
      .rsp_mode_indicator     (rsp_mode_indicator),
      .rsp_color_indicator    (rsp_color_indicator),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   rlkp_result_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode_button_level  (req_mode_button_level),
      .req_color_button_level (req_color_button_level),
      .req_knob_sample        (req_knob_sample),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_red_duty           (rsp_red_duty),
      .rsp_green_duty         (rsp_green_duty),
      .rsp_blue_duty          (rsp_blue_duty),
      .rsp_display_mode       (rsp_display_mode),
      .rsp_active_channel     (rsp_active_channel),
      .rsp_mode_indicator     (rsp_mode_indicator),
      .rsp_color_indicator    (rsp_color_indicator),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .fail_count             (fail_count),
      .results_pending        (results_pending)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 95)
         return $urandom_range(3, 8);
      else
         return $urandom_range(20, 40);
   endfunction

   // earlier samples come back often, so stored levels and the composite
   // knob get matched exactly and the pickups engage
   function automatic logic [rlkp_pkg::KNOB_BITS-1:0] pick_knob();
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (r < 35)
         return knob_history[$urandom_range(0, HISTORY_DEPTH - 1)];
      if (r < 43)
         return rlkp_pkg::KNOB_FULL;
      if (r < 50)
         return '0;
      if (r < 62) begin
         // right on or just past the deadband edge
         k = int'(deadband_now) + $urandom_range(0, 1);
         k = $urandom_range(0, 1) ? int'(last_knob_sent) + k : int'(last_knob_sent) - k;
         if (k < 0 || k > int'(rlkp_pkg::KNOB_FULL))
            k = $urandom_range(0, int'(rlkp_pkg::KNOB_FULL));
         return rlkp_pkg::KNOB_BITS'(k);
      end
      return rlkp_pkg::KNOB_BITS'($urandom_range(0, int'(rlkp_pkg::KNOB_FULL)));
   endfunction

   // result side back-pressure
   always @(posedge clock) begin : rsp_stall
      int stall_left;
      if (reset) begin
         stall_left = 0;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady_flow && $urandom_range(0, 99) < 25)
            stall_left = pick_gap();
      end
   end

   task automatic send_poll(input logic mode_lvl, input logic color_lvl,
                            input logic [rlkp_pkg::KNOB_BITS-1:0] k);
      int gap;
      gap = (!steady_flow && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_mode_button_level  <= mode_lvl;
      req_color_button_level <= color_lvl;
      req_knob_sample        <= k;
      knob_history[history_slot] = k;
      history_slot   = (history_slot + 1) % HISTORY_DEPTH;
      last_knob_sent = k;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait until every poll has its result back
   task automatic drain_polls();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   task automatic write_deadband(input logic [rlkp_pkg::KNOB_BITS-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      deadband_now = value;
   endtask

   // button presses held for a few polls, random knob content, a little noise
   task automatic run_phase(input int count);
      int   mode_hold;
      int   color_hold;
      logic mode_lvl;
      logic color_lvl;
      mode_hold  = 0;
      color_hold = 0;
      for (int n = 0; n < count; n++) begin
         if (mode_hold == 0 && $urandom_range(0, 99) < 4)
            mode_hold = $urandom_range(1, 3);
         if (color_hold == 0 && $urandom_range(0, 99) < 10)
            color_hold = $urandom_range(1, 3);
         mode_lvl  = (mode_hold == 0);
         color_lvl = (color_hold == 0);
         if (mode_hold > 0)
            mode_hold--;
         if (color_hold > 0)
            color_hold--;
         if ($urandom_range(0, 99) < 3)
            mode_lvl = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 3)
            color_lvl = 1'($urandom_range(0, 1));
         send_poll(mode_lvl, color_lvl, pick_knob());
      end
   endtask

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      logic [rlkp_pkg::KNOB_BITS-1:0] phase_deadband [NUM_PHASES];
      int                             phase_items [NUM_PHASES];
      phase_deadband[0] = '0;
      phase_deadband[1] = rlkp_pkg::KNOB_FULL;
      phase_deadband[2] = 10'd1;
      phase_deadband[3] = rlkp_pkg::KNOB_BITS'($urandom_range(2, 40));
      phase_deadband[4] = rlkp_pkg::DEADBAND_RESET;
      phase_deadband[5] = rlkp_pkg::KNOB_BITS'($urandom_range(41, 1022));
      phase_deadband[6] = 10'd3;
      phase_items = '{250, 40, 250, 250, 250, 160, 250};
      for (int i = 0; i < HISTORY_DEPTH; i++)
         knob_history[i] = (i % 2) ? rlkp_pkg::KNOB_FULL : '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // uninitialised: knob ignored, colour release ignored
      send_poll(1'b1, 1'b1, 10'd1023);
      send_poll(1'b1, 1'b0, 10'd0);
      send_poll(1'b1, 1'b1, 10'd0);
      // first mode release enters single colour with all channels dark
      send_poll(1'b0, 1'b1, 10'd1023);
      send_poll(1'b1, 1'b1, 10'd0);
      // pickup on red at its stored full scale, then follow the knob
      send_poll(1'b1, 1'b1, 10'd1023);
      send_poll(1'b1, 1'b1, 10'd600);
      send_poll(1'b1, 1'b1, 10'd605);
      send_poll(1'b1, 1'b1, 10'd594);
      // both released together: mode goes first, colour is then ignored
      send_poll(1'b0, 1'b0, 10'd594);
      send_poll(1'b1, 1'b1, 10'd594);
      // composite: no scaling until the knob reads its last composite value
      send_poll(1'b1, 1'b1, 10'd300);
      send_poll(1'b1, 1'b1, 10'd0);
      send_poll(1'b1, 1'b1, 10'd1023);
      send_poll(1'b1, 1'b1, 10'd511);
      // back to single colour with the active channel lit
      send_poll(1'b0, 1'b1, 10'd511);
      send_poll(1'b1, 1'b1, 10'd511);
      // channel change, pickup miss, then pickup on green
      send_poll(1'b1, 1'b0, 10'd511);
      send_poll(1'b1, 1'b1, 10'd511);
      send_poll(1'b1, 1'b1, 10'd0);
      send_poll(1'b1, 1'b1, 10'd1023);
      send_poll(1'b1, 1'b1, 10'd200);
      send_poll(1'b1, 1'b0, 10'd200);
      send_poll(1'b1, 1'b1, 10'd200);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_polls();
         write_deadband(phase_deadband[p]);
         steady_flow <= (p == 4);
         run_phase(phase_items[p]);
      end
      drain_polls();
      repeat (4) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
